FILE: design/ppc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

    localparam int PPC_RADIUS = 28;
    localparam int CFG_W = 12;

    // Widths below hold for every radius up to 255.
    localparam int K_MAG_W = 22;
    localparam int D_W = 45;
    localparam int NUM_MAG_W = 34;
    localparam int V_MAG_W = 12;

    typedef logic [13:0] t_pos;
    typedef logic signed [11:0] t_vel;
    typedef logic signed [12:0] t_dvel;
    typedef logic signed [K_MAG_W:0] t_k;

    typedef enum logic [0:0] {
        CFG_BOX_WIDTH  = 1'b0,
        CFG_BOX_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_pos a_x;
        t_pos a_y;
        t_vel a_vx;
        t_vel a_vy;
        t_pos b_x;
        t_pos b_y;
        t_vel b_vx;
        t_vel b_vy;
        logic gate_open;
    } t_pair;

    typedef struct packed {
        t_vel  avx;
        t_vel  avy;
        t_vel  bvx;
        t_vel  bvy;
        t_dvel dvx;
        t_dvel dvy;
        logic  reach;
        logic  coll;
    } t_sb1;

    typedef struct packed {
        t_k   k;
        logic reach;
        logic coll;
    } t_sb_u;

    typedef struct packed {
        t_vel avx;
        t_vel avy;
        t_vel bvx;
        t_vel bvy;
    } t_sb_w;

    typedef struct packed {
        t_vel new_a_vx;
        t_vel new_a_vy;
        t_vel new_b_vx;
        t_vel new_b_vy;
        logic past_reach;
        logic collided;
    } t_res;

    function automatic t_vel sat12(input logic signed [35:0] v);
        t_vel r;
        if (v < -36'sd2048) begin
            r = 12'sh800;
        end else if (v > 36'sd2047) begin
            r = 12'sh7FF;
        end else begin
            r = v[11:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/ppc_pair_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ppc_pair_if;
    import ppc_pkg::*;

    logic valid;
    logic ready;
    t_pos a_x;
    t_pos a_y;
    t_vel a_vx;
    t_vel a_vy;
    t_pos b_x;
    t_pos b_y;
    t_vel b_vx;
    t_vel b_vy;
    logic gate_open;

    modport source (output valid, a_x, a_y, a_vx, a_vy, b_x, b_y, b_vx, b_vy, gate_open,
                    input ready);
    modport sink (input valid, a_x, a_y, a_vx, a_vy, b_x, b_y, b_vx, b_vy, gate_open,
                  output ready);
endinterface

`default_nettype wire

FILE: design/ppc_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ppc_res_if;
    import ppc_pkg::*;

    logic valid;
    logic ready;
    t_vel new_a_vx;
    t_vel new_a_vy;
    t_vel new_b_vx;
    t_vel new_b_vy;
    logic past_reach;
    logic collided;

    modport source (output valid, new_a_vx, new_a_vy, new_b_vx, new_b_vy, past_reach,
                    collided, input ready);
    modport sink (input valid, new_a_vx, new_a_vy, new_b_vx, new_b_vy, past_reach,
                  collided, output ready);
endinterface

`default_nettype wire

FILE: design/ppc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ppc_front #(
    parameter int RADIUS = ppc_pkg::PPC_RADIUS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ppc_pkg::CFG_W-1:0]   i_box_width,
    input  wire logic [ppc_pkg::CFG_W-1:0]   i_box_height,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire ppc_pkg::t_pair              i_pair,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output ppc_pkg::t_k                      o_num,
    output ppc_pkg::t_k                      o_den,
    output ppc_pkg::t_sb1                    o_sb
);
    import ppc_pkg::*;

    localparam logic signed [14:0] TWO_R = 15'(2 * RADIUS);
    localparam logic [30:0] NEAR_LIM = 31'(4 * RADIUS * RADIUS);

    logic r_vld1, r_vld2, r_vld3;
    logic w_rdy1, w_rdy2, w_rdy3;

    logic [13:0] w_wdt, w_hgt;
    logic [15:0] w_ay3, w_by3, w_h1, w_h2;
    logic        w_straddle, n_blocked;
    logic signed [14:0] n_dx, n_dy;
    t_dvel n_dvx, n_dvy;

    logic r_blocked1;
    logic signed [14:0] r_dx, r_dy;
    t_sb1 r_sb1;

    logic r_blocked2, r_past2;
    logic signed [29:0] r_dxx, r_dyy;
    logic signed [27:0] r_p1, r_p2, r_p3, r_p4;
    t_sb1 r_sb2;

    logic signed [30:0] w_dist;
    logic signed [28:0] w_m, w_n;
    t_k   r_num, r_den;
    t_sb1 r_sb3;

    assign w_rdy3 = !r_vld3 || i_ready;
    assign w_rdy2 = !r_vld2 || w_rdy3;
    assign w_rdy1 = !r_vld1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_vld3;

    assign w_wdt = {i_box_width, 2'b00};
    assign w_hgt = {i_box_height, 2'b00};
    assign w_straddle = ({i_pair.a_x, 1'b0} <= {1'b0, w_wdt})
                     && ({i_pair.b_x, 1'b0} >= {1'b0, w_wdt});
    assign w_ay3 = {2'b00, i_pair.a_y} + {1'b0, i_pair.a_y, 1'b0};
    assign w_by3 = {2'b00, i_pair.b_y} + {1'b0, i_pair.b_y, 1'b0};
    assign w_h1 = {2'b00, w_hgt};
    assign w_h2 = {1'b0, w_hgt, 1'b0};
    assign n_blocked = w_straddle && (!i_pair.gate_open || w_ay3 < w_h1 || w_by3 < w_h1
                                      || w_ay3 > w_h2 || w_by3 > w_h2);
    assign n_dx = $signed({1'b0, i_pair.b_x}) - $signed({1'b0, i_pair.a_x});
    assign n_dy = $signed({1'b0, i_pair.b_y}) - $signed({1'b0, i_pair.a_y});
    assign n_dvx = 13'(i_pair.b_vx) - 13'(i_pair.a_vx);
    assign n_dvy = 13'(i_pair.b_vy) - 13'(i_pair.a_vy);

    assign w_dist = 31'(r_dxx) + 31'(r_dyy);
    assign w_m = 29'(r_p1) + 29'(r_p2);
    assign w_n = 29'(r_p3) - 29'(r_p4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (w_rdy1) r_vld1 <= i_valid;
            if (w_rdy2) r_vld2 <= r_vld1;
            if (w_rdy3) r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_blocked1 <= n_blocked;
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_sb1.avx <= i_pair.a_vx;
            r_sb1.avy <= i_pair.a_vy;
            r_sb1.bvx <= i_pair.b_vx;
            r_sb1.bvy <= i_pair.b_vy;
            r_sb1.dvx <= n_dvx;
            r_sb1.dvy <= n_dvy;
            r_sb1.reach <= 1'b0;
            r_sb1.coll <= 1'b0;
        end
        if (w_rdy2) begin
            r_blocked2 <= r_blocked1;
            r_past2 <= r_dx > TWO_R;
            r_dxx <= 30'(r_dx) * 30'(r_dx);
            r_dyy <= 30'(r_dy) * 30'(r_dy);
            r_p1 <= 28'(r_dx) * 28'(r_sb1.dvx);
            r_p2 <= 28'(r_dy) * 28'(r_sb1.dvy);
            r_p3 <= 28'(r_dy) * 28'(r_sb1.dvx);
            r_p4 <= 28'(r_dx) * 28'(r_sb1.dvy);
            r_sb2 <= r_sb1;
        end
        if (w_rdy3) begin
            r_num <= w_n[K_MAG_W:0];
            r_den <= w_m[K_MAG_W:0];
            r_sb3.avx <= r_sb2.avx;
            r_sb3.avy <= r_sb2.avy;
            r_sb3.bvx <= r_sb2.bvx;
            r_sb3.bvy <= r_sb2.bvy;
            r_sb3.dvx <= r_sb2.dvx;
            r_sb3.dvy <= r_sb2.dvy;
            r_sb3.reach <= !r_blocked2 && r_past2;
            r_sb3.coll <= !r_blocked2 && !r_past2 && ($unsigned(w_dist) <= NEAR_LIM)
                          && w_m[28];
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;
    assign o_sb = r_sb3;

endmodule

`default_nettype wire

FILE: design/ppc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ppc_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 22,
    parameter int Q_W = 22,
    parameter type t_sb = logic
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic signed [NUM_W:0] i_num,
    input  wire logic signed [DEN_W:0] i_den,
    input  wire t_sb                   i_sb,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [Q_W:0]        o_quo,
    output t_sb                        o_sb
);
    localparam int NS = Q_W + 2;
    localparam int CW = DEN_W + Q_W;

    logic             r_vld [NS];
    logic             w_rdy [NS+1];
    logic [NUM_W-1:0] r_rem [Q_W+1];
    logic [DEN_W-1:0] r_den [Q_W+1];
    logic [Q_W-1:0]   r_q   [Q_W+1];
    logic             r_neg [Q_W+1];
    t_sb              r_sb  [NS];
    logic signed [Q_W:0] r_quo;

    logic signed [NUM_W:0] w_nabs;
    logic signed [DEN_W:0] w_dabs;

    assign w_nabs = i_num[NUM_W] ? -i_num : i_num;
    assign w_dabs = i_den[DEN_W] ? -i_den : i_den;

    assign w_rdy[NS] = i_ready;
    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_rdy
            assign w_rdy[g] = !r_vld[g] || w_rdy[g+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            for (int s = 1; s < NS; s++) begin
                if (w_rdy[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_rem[0] <= w_nabs[NUM_W-1:0];
            r_den[0] <= w_dabs[DEN_W-1:0];
            r_q[0] <= '0;
            r_neg[0] <= i_num[NUM_W] ^ i_den[DEN_W];
            r_sb[0] <= i_sb;
        end
    end

    generate
        for (g = 1; g <= Q_W; g++) begin : g_step
            logic [CW-1:0] w_sh, w_rm;
            logic          w_ge;
            logic [Q_W-1:0] n_q;
            assign w_sh = CW'(r_den[g-1]) << (Q_W - g);
            assign w_rm = CW'(r_rem[g-1]);
            assign w_ge = w_rm >= w_sh;
            always_comb begin
                n_q = r_q[g-1];
                n_q[Q_W-g] = w_ge;
            end
            always_ff @(posedge i_clk) begin
                if (w_rdy[g]) begin
                    r_rem[g] <= w_ge ? NUM_W'(w_rm - w_sh) : r_rem[g-1];
                    r_den[g] <= r_den[g-1];
                    r_q[g] <= n_q;
                    r_neg[g] <= r_neg[g-1];
                    r_sb[g] <= r_sb[g-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_rdy[NS-1]) begin
            r_quo <= r_neg[Q_W] ? -$signed({1'b0, r_q[Q_W]}) : $signed({1'b0, r_q[Q_W]});
            r_sb[NS-1] <= r_sb[Q_W];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_quo = r_quo;
    assign o_sb = r_sb[NS-1];

endmodule

`default_nettype wire

FILE: design/ppc_mid.sv
`timescale 1ns / 1ps
`default_nettype none

module ppc_mid (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire ppc_pkg::t_k                          i_k,
    input  wire ppc_pkg::t_sb1                        i_sb,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed [ppc_pkg::D_W:0]              o_d,
    output logic signed [ppc_pkg::NUM_MAG_W:0]        o_numu,
    output logic signed [ppc_pkg::NUM_MAG_W:0]        o_numw,
    output ppc_pkg::t_sb_u                            o_sb_u,
    output ppc_pkg::t_sb_w                            o_sb_w
);
    import ppc_pkg::*;

    logic r_vld1, r_vld2, w_rdy1, w_rdy2;

    logic signed [45:0] r_kk;
    logic signed [35:0] r_kdvy, r_kdvx;
    t_k   r_k;
    t_sb1 r_sb;

    logic signed [D_W:0]       r_d;
    logic signed [NUM_MAG_W:0] r_numu, r_numw;
    t_sb_u r_sb_u;
    t_sb_w r_sb_w;

    assign w_rdy2 = !r_vld2 || i_ready;
    assign w_rdy1 = !r_vld1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_vld2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (w_rdy1) r_vld1 <= i_valid;
            if (w_rdy2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_kk <= 46'(i_k) * 46'(i_k);
            r_kdvy <= 36'(i_k) * 36'(i_sb.dvy);
            r_kdvx <= 36'(i_k) * 36'(i_sb.dvx);
            r_k <= i_k;
            r_sb <= i_sb;
        end
        if (w_rdy2) begin
            r_d <= $signed({1'b0, r_kk[D_W-1:0] + D_W'(1)});
            r_numu <= (NUM_MAG_W+1)'(r_sb.dvx) - r_kdvy[NUM_MAG_W:0];
            r_numw <= r_kdvx[NUM_MAG_W:0] + (NUM_MAG_W+1)'(r_sb.dvy);
            r_sb_u.k <= r_k;
            r_sb_u.reach <= r_sb.reach;
            r_sb_u.coll <= r_sb.coll;
            r_sb_w.avx <= r_sb.avx;
            r_sb_w.avy <= r_sb.avy;
            r_sb_w.bvx <= r_sb.bvx;
            r_sb_w.bvy <= r_sb.bvy;
        end
    end

    assign o_d = r_d;
    assign o_numu = r_numu;
    assign o_numw = r_numw;
    assign o_sb_u = r_sb_u;
    assign o_sb_w = r_sb_w;

endmodule

`default_nettype wire

FILE: design/ppc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ppc_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [ppc_pkg::V_MAG_W:0] i_ua,
    input  wire logic signed [ppc_pkg::V_MAG_W:0] i_wa,
    input  wire ppc_pkg::t_sb_u                 i_sb_u,
    input  wire ppc_pkg::t_sb_w                 i_sb_w,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output ppc_pkg::t_res                       o_res
);
    import ppc_pkg::*;

    logic r_vld1, r_vld2, w_rdy1, w_rdy2;

    logic signed [35:0] r_kwa, r_kua;
    logic signed [V_MAG_W:0] r_ua, r_wa;
    t_sb_u r_sb_u;
    t_sb_w r_sb_w;
    t_res  r_res;

    assign w_rdy2 = !r_vld2 || i_ready;
    assign w_rdy1 = !r_vld1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_vld2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (w_rdy1) r_vld1 <= i_valid;
            if (w_rdy2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_kwa <= 36'(i_sb_u.k) * 36'(i_wa);
            r_kua <= 36'(i_sb_u.k) * 36'(i_ua);
            r_ua <= i_ua;
            r_wa <= i_wa;
            r_sb_u <= i_sb_u;
            r_sb_w <= i_sb_w;
        end
        if (w_rdy2) begin
            r_res.past_reach <= r_sb_u.reach;
            r_res.collided <= r_sb_u.coll;
            if (r_sb_u.coll) begin
                r_res.new_a_vx <= sat12(36'(r_sb_w.avx) + 36'(r_ua));
                r_res.new_a_vy <= sat12(36'(r_sb_w.avy) + 36'(r_wa));
                r_res.new_b_vx <= sat12(36'(r_sb_w.avx) + r_kwa);
                r_res.new_b_vy <= sat12(36'(r_sb_w.avy) - r_kua);
            end else begin
                r_res.new_a_vx <= r_sb_w.avx;
                r_res.new_a_vy <= r_sb_w.avy;
                r_res.new_b_vx <= r_sb_w.bvx;
                r_res.new_b_vy <= r_sb_w.bvy;
            end
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: design/particle_pair_collision_top.sv
// Data path: an accepted pair passes through the front, the k divider, the product
// stage, the two velocity dividers and the output stage, in that order.
// Throughput: one pair per cycle while the result side is ready; the bit-per-stage dividers set the latency.
// A stall freezes only the stages that hold data, bubbles still move forward.
// Reset (synchronous, active low) empties the pipeline and sets box_width to 300
// and box_height to 255.
`timescale 1ns / 1ps
`default_nettype none

module particle_pair_collision_top #(
    parameter int COLLISION_RADIUS = ppc_pkg::PPC_RADIUS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire ppc_pkg::t_cfg_reg         i_cfg_idx,
    input  wire logic [ppc_pkg::CFG_W-1:0] i_cfg_data,
    ppc_pair_if.sink                       i_pair,
    ppc_res_if.source                      o_res
);
    import ppc_pkg::*;

    logic [CFG_W-1:0] r_box_width, r_box_height;

    t_pair w_pair;
    logic  w_f_valid, w_f_ready;
    t_k    w_num, w_den;
    t_sb1  w_f_sb;

    logic  w_k_valid, w_k_ready;
    t_k    w_k;
    t_sb1  w_k_sb;

    logic  w_m_valid, w_m_ready;
    logic signed [D_W:0]       w_d;
    logic signed [NUM_MAG_W:0] w_numu, w_numw;
    t_sb_u w_m_sb_u;
    t_sb_w w_m_sb_w;

    logic  w_u_in_ready, w_w_in_ready, w_u_valid, w_w_valid;
    logic signed [V_MAG_W:0] w_ua, w_wa;
    t_sb_u w_u_sb;
    t_sb_w w_w_sb;

    logic  w_b_ready;
    t_res  w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width <= CFG_W'(300);
            r_box_height <= CFG_W'(255);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOX_WIDTH:  r_box_width <= i_cfg_data;
                CFG_BOX_HEIGHT: r_box_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_pair.a_x = i_pair.a_x;
    assign w_pair.a_y = i_pair.a_y;
    assign w_pair.a_vx = i_pair.a_vx;
    assign w_pair.a_vy = i_pair.a_vy;
    assign w_pair.b_x = i_pair.b_x;
    assign w_pair.b_y = i_pair.b_y;
    assign w_pair.b_vx = i_pair.b_vx;
    assign w_pair.b_vy = i_pair.b_vy;
    assign w_pair.gate_open = i_pair.gate_open;

    ppc_front #(.RADIUS(COLLISION_RADIUS)) u_front (
        .i_clk, .i_rst_n,
        .i_box_width(r_box_width), .i_box_height(r_box_height),
        .i_valid(i_pair.valid), .o_ready(i_pair.ready), .i_pair(w_pair),
        .o_valid(w_f_valid), .i_ready(w_f_ready),
        .o_num(w_num), .o_den(w_den), .o_sb(w_f_sb)
    );

    ppc_div #(.NUM_W(K_MAG_W), .DEN_W(K_MAG_W), .Q_W(K_MAG_W), .t_sb(t_sb1)) u_div_k (
        .i_clk, .i_rst_n,
        .i_valid(w_f_valid), .o_ready(w_f_ready),
        .i_num(w_num), .i_den(w_den), .i_sb(w_f_sb),
        .o_valid(w_k_valid), .i_ready(w_k_ready), .o_quo(w_k), .o_sb(w_k_sb)
    );

    ppc_mid u_mid (
        .i_clk, .i_rst_n,
        .i_valid(w_k_valid), .o_ready(w_k_ready), .i_k(w_k), .i_sb(w_k_sb),
        .o_valid(w_m_valid), .i_ready(w_m_ready),
        .o_d(w_d), .o_numu(w_numu), .o_numw(w_numw), .o_sb_u(w_m_sb_u), .o_sb_w(w_m_sb_w)
    );

    assign w_m_ready = w_u_in_ready && w_w_in_ready;

    ppc_div #(.NUM_W(NUM_MAG_W), .DEN_W(D_W), .Q_W(V_MAG_W), .t_sb(t_sb_u)) u_div_u (
        .i_clk, .i_rst_n,
        .i_valid(w_m_valid && w_w_in_ready), .o_ready(w_u_in_ready),
        .i_num(w_numu), .i_den(w_d), .i_sb(w_m_sb_u),
        .o_valid(w_u_valid), .i_ready(w_b_ready && w_w_valid), .o_quo(w_ua), .o_sb(w_u_sb)
    );

    ppc_div #(.NUM_W(NUM_MAG_W), .DEN_W(D_W), .Q_W(V_MAG_W), .t_sb(t_sb_w)) u_div_w (
        .i_clk, .i_rst_n,
        .i_valid(w_m_valid && w_u_in_ready), .o_ready(w_w_in_ready),
        .i_num(w_numw), .i_den(w_d), .i_sb(w_m_sb_w),
        .o_valid(w_w_valid), .i_ready(w_b_ready && w_u_valid), .o_quo(w_wa), .o_sb(w_w_sb)
    );

    ppc_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_u_valid && w_w_valid), .o_ready(w_b_ready),
        .i_ua(w_ua), .i_wa(w_wa), .i_sb_u(w_u_sb), .i_sb_w(w_w_sb),
        .o_valid(o_res.valid), .i_ready(o_res.ready), .o_res(w_res)
    );

    assign o_res.new_a_vx = w_res.new_a_vx;
    assign o_res.new_a_vy = w_res.new_a_vy;
    assign o_res.new_b_vx = w_res.new_b_vx;
    assign o_res.new_b_vy = w_res.new_b_vy;
    assign o_res.past_reach = w_res.past_reach;
    assign o_res.collided = w_res.collided;

`ifndef SYNTHESIS
    a_reach_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.collided && o_res.past_reach))
        else $error("collided and past_reach both set");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pair.ready |-> (o_res.valid && !o_res.ready))
        else $error("input stalled while output side is free");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_u_valid == w_w_valid)
        else $error("velocity dividers out of step");
`endif

endmodule

`default_nettype wire

FILE: test/ppc_collision_checker.sv
`timescale 1ns / 1ps

module ppc_collision_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  ppc_pkg::t_cfg_reg  i_cfg_idx,
    input  logic [11:0]        i_cfg_data,
    ppc_pair_if                pair,
    ppc_res_if                 res,
    output int                 o_fail_count,
    output int                 o_pending
);
    import ppc_pkg::*;

    logic [11:0] box_w;
    logic [11:0] box_h;
    t_res        expected_q[$];

    function automatic t_vel clamp_vel(input longint v);
        t_vel r;
        if (v < -2048) begin
            r = -12'sd2048;
        end else if (v > 2047) begin
            r = 12'sd2047;
        end else begin
            r = t_vel'(v);
        end
        return r;
    endfunction

    function automatic t_res collide_pair(input t_pair p, input logic [11:0] bw,
                                          input logic [11:0] bh);
        longint ax, ay, bx, by, avx, avy, bvx, bvy, wd, ht, rad;
        longint nax, nay, nbx, nby, dx, dy, dvx, dvy, m, k, d, ua, wa;
        logic blocked, reach, hit;
        t_res r;
        ax = p.a_x; ay = p.a_y; bx = p.b_x; by = p.b_y;
        avx = p.a_vx; avy = p.a_vy; bvx = p.b_vx; bvy = p.b_vy;
        wd = 4 * longint'(bw);
        ht = 4 * longint'(bh);
        rad = PPC_RADIUS;
        nax = avx; nay = avy; nbx = bvx; nby = bvy;
        reach = 1'b0; hit = 1'b0; blocked = 1'b0;
        if (2 * ax <= wd && 2 * bx >= wd) begin
            if (!p.gate_open || 3 * ay < ht || 3 * by < ht
                    || 3 * ay > 2 * ht || 3 * by > 2 * ht) begin
                blocked = 1'b1;
            end
        end
        if (!blocked) begin
            dx = bx - ax; dy = by - ay; dvx = bvx - avx; dvy = bvy - avy;
            if (dx > 2 * rad) begin
                reach = 1'b1;
            end else if (dx * dx + dy * dy <= 4 * rad * rad) begin
                m = dx * dvx + dy * dvy;
                if (m < 0) begin
                    k = (dy * dvx - dx * dvy) / m;
                    d = 1 + k * k;
                    ua = (dvx - k * dvy) / d;
                    wa = (k * dvx + dvy) / d;
                    nbx = avx + k * wa;
                    nby = avy - k * ua;
                    nax = avx + ua;
                    nay = avy + wa;
                    hit = 1'b1;
                end
            end
        end
        r.new_a_vx = clamp_vel(nax);
        r.new_a_vy = clamp_vel(nay);
        r.new_b_vx = clamp_vel(nbx);
        r.new_b_vy = clamp_vel(nby);
        r.past_reach = reach;
        r.collided = hit;
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_pair p;
        t_res e;
        if (!i_rst_n) begin
            box_w <= 12'd300;
            box_h <= 12'd255;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BOX_WIDTH) begin
                    box_w <= i_cfg_data;
                end else begin
                    box_h <= i_cfg_data;
                end
            end
            if (pair.valid && pair.ready) begin
                p = '{pair.a_x, pair.a_y, pair.a_vx, pair.a_vy, pair.b_x, pair.b_y,
                      pair.b_vx, pair.b_vy, pair.gate_open};
                expected_q.push_back(collide_pair(p, box_w, box_h));
            end
            if (res.valid && res.ready) begin
                if (expected_q.size() == 0) begin
                    $error("Result transaction with no pair outstanding.");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (res.new_a_vx !== e.new_a_vx || res.new_a_vy !== e.new_a_vy
                            || res.new_b_vx !== e.new_b_vx || res.new_b_vy !== e.new_b_vy
                            || res.past_reach !== e.past_reach
                            || res.collided !== e.collided) begin
                        o_fail_count <= o_fail_count + 1;
                        if (res.new_a_vx !== e.new_a_vx)
                            $error("new_a_vx expected %0d got %0d", e.new_a_vx, res.new_a_vx);
                        if (res.new_a_vy !== e.new_a_vy)
                            $error("new_a_vy expected %0d got %0d", e.new_a_vy, res.new_a_vy);
                        if (res.new_b_vx !== e.new_b_vx)
                            $error("new_b_vx expected %0d got %0d", e.new_b_vx, res.new_b_vx);
                        if (res.new_b_vy !== e.new_b_vy)
                            $error("new_b_vy expected %0d got %0d", e.new_b_vy, res.new_b_vy);
                        if (res.past_reach !== e.past_reach)
                            $error("past_reach expected %0d got %0d", e.past_reach,
                                   res.past_reach);
                        if (res.collided !== e.collided)
                            $error("collided expected %0d got %0d", e.collided, res.collided);
                    end
                end
            end
        end
    end
endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import ppc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_cfg_reg    i_cfg_idx = CFG_BOX_WIDTH;
    logic [11:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;
    logic [11:0] cur_w = 12'd300;
    logic [11:0] cur_h = 12'd255;

    ppc_pair_if pair_ch();
    ppc_res_if  res_ch();

    particle_pair_collision_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_pair(pair_ch.sink), .o_res(res_ch.source)
    );

    ppc_collision_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .pair(pair_ch), .res(res_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        pair_ch.valid = 1'b0;
        {pair_ch.a_x, pair_ch.a_y, pair_ch.a_vx, pair_ch.a_vy, pair_ch.b_x, pair_ch.b_y,
         pair_ch.b_vx, pair_ch.b_vy, pair_ch.gate_open} = '0;
        res_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("FAIL particle_pair_collision_top");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= i_rst_n && !hold_off && (calm || $urandom_range(99) >= 27);
    end

    task automatic send_pair(input t_pair p);
        pair_ch.a_x <= p.a_x; pair_ch.a_y <= p.a_y;
        pair_ch.a_vx <= p.a_vx; pair_ch.a_vy <= p.a_vy;
        pair_ch.b_x <= p.b_x; pair_ch.b_y <= p.b_y;
        pair_ch.b_vx <= p.b_vx; pair_ch.b_vy <= p.b_vy;
        pair_ch.gate_open <= p.gate_open;
        pair_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!pair_ch.ready);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 27) begin
            pair_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [11:0] val);
        pair_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BOX_WIDTH) cur_w = val; else cur_h = val;
    endtask

    function automatic t_pair make_pair(input int mode);
        t_pair p;
        int mid, ymid, hgt;
        p = ($bits(t_pair))'({$urandom, $urandom, $urandom, $urandom});
        mid = 2 * int'(cur_w);
        hgt = 4 * int'(cur_h);
        if (mode < 75) begin
            if ($urandom_range(3) == 0) begin
                ymid = (hgt / 3 + 1 + $urandom_range(hgt / 3 + 1)) % 16384;
                p.a_x = 14'(mid - $urandom_range(40));
                p.b_x = 14'(mid + $urandom_range(40));
                p.a_y = 14'(ymid);
            end else begin
                p.a_x = 14'($urandom_range(16000));
                p.b_x = 14'(int'(p.a_x) + $urandom_range(70) - 8);
            end
            p.b_y = 14'(int'(p.a_y) + $urandom_range(120) - 60);
            if ($urandom_range(3) != 0) begin
                p.a_vx = 12'($signed($urandom_range(200)) - 100);
                p.a_vy = 12'($signed($urandom_range(200)) - 100);
                p.b_vx = 12'($signed($urandom_range(200)) - 100);
                p.b_vy = 12'($signed($urandom_range(200)) - 100);
            end
            p.gate_open = $urandom_range(3) != 0;
        end
        return p;
    endfunction

    initial begin
        t_pair p;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_pair('{14'd100, 14'd100, -12'sd2048, 12'sd2047, 14'd120, 14'd100,
                    12'sd2047, -12'sd2048, 1'b1});
        send_pair('{14'd100, 14'd100, 12'sd2047, 12'sd2047, 14'd110, 14'd110,
                    -12'sd2048, -12'sd2048, 1'b0});
        send_pair('{14'd0, 14'd0, 12'sd0, 12'sd0, 14'd16383, 14'd16383, 12'sd0, 12'sd0, 1'b1});
        send_pair('{14'd100, 14'd100, 12'sd5, 12'sd0, 14'd156, 14'd100, -12'sd5, 12'sd0, 1'b0});
        send_pair('{14'd100, 14'd100, 12'sd5, 12'sd0, 14'd157, 14'd100, -12'sd5, 12'sd0, 1'b0});
        send_pair('{14'd100, 14'd100, -12'sd5, 12'sd0, 14'd120, 14'd100, 12'sd5, 12'sd0, 1'b0});
        send_pair('{14'd100, 14'd100, 12'sd0, 12'sd0, 14'd100, 14'd100, 12'sd0, 12'sd0, 1'b0});
        send_pair('{14'd100, 14'd100, 12'sd0, 12'sd0, 14'd100, 14'd157, 12'sd0, 12'sd0, 1'b0});
        send_pair('{14'd130, 14'd100, 12'sd0, 12'sd30, 14'd110, 14'd110, 12'sd9, -12'sd3, 1'b0});
        send_pair('{14'd590, 14'd500, 12'sd40, 12'sd3, 14'd610, 14'd505, -12'sd40, 12'sd0, 1'b1});
        send_pair('{14'd590, 14'd500, 12'sd40, 12'sd3, 14'd610, 14'd505, -12'sd40, 12'sd0, 1'b0});
        send_pair('{14'd590, 14'd200, 12'sd40, 12'sd3, 14'd610, 14'd205, -12'sd40, 12'sd0, 1'b1});
        send_pair('{14'd590, 14'd680, 12'sd40, 12'sd3, 14'd610, 14'd675, -12'sd40, 12'sd0, 1'b1});
        send_pair('{14'd600, 14'd340, 12'sd40, 12'sd3, 14'd600, 14'd345, -12'sd40, 12'sd0, 1'b1});
        send_pair('{14'd16383, 14'd16383, 12'sd1, 12'sd1, 14'd16383, 14'd16383, 12'sd2,
                    12'sd2, 1'b1});
        write_reg(CFG_BOX_WIDTH, 12'd0);
        write_reg(CFG_BOX_HEIGHT, 12'd0);
        send_pair('{14'd0, 14'd0, 12'sd9, 12'sd0, 14'd20, 14'd0, -12'sd9, 12'sd0, 1'b1});
        send_pair('{14'd0, 14'd0, 12'sd9, 12'sd0, 14'd20, 14'd0, -12'sd9, 12'sd0, 1'b0});
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_reg(CFG_BOX_WIDTH, 12'd300); write_reg(CFG_BOX_HEIGHT, 12'd255); end
                1: begin write_reg(CFG_BOX_WIDTH, 12'd4095); write_reg(CFG_BOX_HEIGHT, 12'd4095); end
                2: begin write_reg(CFG_BOX_WIDTH, 12'd1); write_reg(CFG_BOX_HEIGHT, 12'd1); end
                3: begin
                    write_reg(CFG_BOX_WIDTH, 12'($urandom_range(1, 4095)));
                    write_reg(CFG_BOX_HEIGHT, 12'($urandom_range(1, 4095)));
                end
                default: begin write_reg(CFG_BOX_WIDTH, 12'd1000); write_reg(CFG_BOX_HEIGHT, 12'd800); end
            endcase
            calm = (phase == 2);
            if (phase == 1) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 400; n++) begin
                p = make_pair($urandom_range(99));
                send_pair(p);
                if (n == 200) begin
                    pair_ch.valid <= 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
            end
        end
        calm = 1'b0;
        pair_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS particle_pair_collision_top");
        end else begin
            $display("FAIL particle_pair_collision_top");
        end
        $finish;
    end
endmodule
